// ===== rtl/core/mcd_pkg.sv =====
// shared types, register codes and small helper functions for the maze carver
package mcd_pkg;

  localparam int DIM_W = 9;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT0,
    ST_INIT1,
    ST_POS,
    ST_ROW,
    ST_WAIT,
    ST_EVAL,
    ST_WR1,
    ST_WR2
  } state_t;

  typedef enum logic [1:0] {
    DIR_UP = 2'd0,
    DIR_DN = 2'd1,
    DIR_LF = 2'd2,
    DIR_RT = 2'd3
  } dir_t;

  function automatic logic [1:0] mod3(logic [7:0] v);
    logic [3:0] s;
    logic [1:0] m;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: m = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: m = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11: m = 2'd2;
      default: m = 2'd0;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] pick_index(logic [7:0] rnd, logic [2:0] n);
    logic [1:0] p;
    case (n)
      3'd2: p = {1'b0, rnd[0]};
      3'd3: p = mod3(rnd);
      3'd4: p = rnd[1:0];
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic dir_t nth_dir(logic [3:0] open, logic [1:0] pick);
    logic [2:0] seen;
    logic found;
    dir_t d;
    seen = 3'd0;
    found = 1'b0;
    d = DIR_UP;
    for (int k = 0; k < 4; k++) begin
      if (open[k] && !found) begin
        if (seen == {1'b0, pick}) begin
          d = dir_t'(2'(k));
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/mcd_grid.sv =====
// wall grid row memory with per-row valid bits, unwritten rows read as all wall
module mcd_grid #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  logic                     we,
  input  logic [$clog2(ROWS)-1:0]  waddr,
  input  logic [COLS-1:0]          wdata,
  input  logic [$clog2(ROWS)-1:0]  raddr,
  output logic [COLS-1:0]          rdata
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] valid;
  logic [COLS-1:0] rd_q;
  logic            rd_v;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= valid[raddr];
      if (clr) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_v ? rd_q : '1;

endmodule

// ===== rtl/core/mcd_stack.sv =====
// position stack memory, one write and one registered read per cycle
module mcd_stack #(
  parameter int DEPTH = 1024,
  parameter int EW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [EW-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [EW-1:0]             rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/maze_carver_dfs_top.sv =====
// maze carver top level: config port, step sequencer and result registers
// start beat: INIT0, INIT1, then the result is registered; step after completion: result in the cycle after accept
// carve step: POS, ROW, WAIT, EVAL, WR1, WR2; backtrack step: POS, ROW, WAIT, EVAL; start is taken only in idle
// the grid read port does five row reads, then the grid write port does two row writes for a carve
// one result beat per item, strobe high for one cycle, never stalled
// synchronous reset: maze marked finished, bounds 15 x 15, grid reads all wall
module maze_carver_dfs_top #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  rnd,
  output logic        strobe,
  output logic        moved,
  output logic [5:0]  wall_row,
  output logic [5:0]  wall_col,
  output logic [5:0]  cell_row,
  output logic [5:0]  cell_col,
  output logic        done_res
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int EW = RW + CW;
  localparam int DW = mcd_pkg::DIM_W;

  // config registers
  logic [6:0] grid_rows;
  logic [6:0] grid_cols;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd15;
      grid_cols <= 7'd15;
    end else if (cfg_we) begin
      case (paddr[2])
        mcd_pkg::REG_ROWS: grid_rows <= pwdata[6:0];
        mcd_pkg::REG_COLS: grid_cols <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mcd_pkg::REG_ROWS: prdata = {25'd0, grid_rows};
      mcd_pkg::REG_COLS: prdata = {25'd0, grid_cols};
      default: prdata = '0;
    endcase
  end

  // clamped, odd-trimmed bounds
  logic [DW-1:0] rows_ext, cols_ext, s1c, s2c, s1, s2;

  assign rows_ext = DW'(grid_rows);
  assign cols_ext = DW'(grid_cols);
  assign s1c = (rows_ext < DW'(3)) ? DW'(3) :
               (rows_ext > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : rows_ext;
  assign s2c = (cols_ext < DW'(3)) ? DW'(3) :
               (cols_ext > DW'(MAX_COLS)) ? DW'(MAX_COLS) : cols_ext;
  assign s1 = s1c[0] ? s1c : s1c - DW'(1);
  assign s2 = s2c[0] ? s2c : s2c - DW'(1);

  // state
  mcd_pkg::state_t state, state_next;
  logic [LW-1:0]   level;
  logic            finished;
  logic [RW-1:0]   r;
  logic [CW-1:0]   c;
  logic [2:0]      idx;
  logic            rd_pend;
  logic [2:0]      rd_slot;
  logic [7:0]      rnd_q;
  logic [MAX_COLS-1:0] rows [5];

  logic [RW-1:0]       w1_row, w2_row;
  logic [MAX_COLS-1:0] w1_data, w2_data;
  logic [RW-1:0]       wr_q, nr_q;
  logic [CW-1:0]       wc_q, nc_q;

  // memories
  logic                g_clr, g_we;
  logic [RW-1:0]       g_waddr, g_raddr;
  logic [MAX_COLS-1:0] g_wdata, g_rdata;
  logic                s_we;
  logic [AW-1:0]       s_waddr, s_raddr;
  logic [EW-1:0]       s_wdata, s_rdata;

  mcd_grid #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_grid (
    .clk   (clk),
    .rst   (rst),
    .clr   (g_clr),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  mcd_stack #(
    .DEPTH (STACK_DEPTH),
    .EW    (EW)
  ) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // bounds checks on the current position
  logic up_in, dn_in, lf_in, rt_in;

  assign up_in = r > RW'(2);
  assign dn_in = (DW'(r) + DW'(2)) < s1;
  assign lf_in = c > CW'(2);
  assign rt_in = (DW'(c) + DW'(2)) < s2;

  // shared row address adder
  logic [RW:0] off_ext, row_sum;
  logic        slot_ok;
  logic [RW-1:0] row_addr;

  always_comb begin
    case (idx)
      3'd0: off_ext = ~(RW+1)'(1);
      3'd1: off_ext = '1;
      3'd3: off_ext = (RW+1)'(1);
      3'd4: off_ext = (RW+1)'(2);
      default: off_ext = '0;
    endcase
  end

  assign slot_ok  = ((idx < 3'd2) && up_in) || ((idx > 3'd2) && dn_in);
  assign row_sum  = {1'b0, r} + off_ext;
  assign row_addr = slot_ok ? row_sum[RW-1:0] : r;

  // direction evaluation
  logic [CW-1:0] cm1, cm2, cp1, cp2;
  logic [3:0]    open;
  logic [2:0]    n_open;
  logic [1:0]    pick;
  mcd_pkg::dir_t dir;
  logic [MAX_COLS-1:0] m_c, m_cm1, m_cm2, m_cp1, m_cp2;
  logic [RW-1:0]       e_wr, e_nr, e_w1, e_w2;
  logic [CW-1:0]       e_wc, e_nc;
  logic [MAX_COLS-1:0] e_d1, e_d2;

  assign cm1 = lf_in ? c - CW'(1) : c;
  assign cm2 = lf_in ? c - CW'(2) : c;
  assign cp1 = rt_in ? c + CW'(1) : c;
  assign cp2 = rt_in ? c + CW'(2) : c;

  assign open[0] = up_in & rows[1][c] & rows[0][c];
  assign open[1] = dn_in & rows[3][c] & rows[4][c];
  assign open[2] = lf_in & rows[2][cm1] & rows[2][cm2];
  assign open[3] = rt_in & rows[2][cp1] & rows[2][cp2];

  assign n_open = 3'($countones(open));
  assign pick   = mcd_pkg::pick_index(rnd_q, n_open);
  assign dir    = mcd_pkg::nth_dir(open, pick);

  assign m_c   = {{(MAX_COLS-1){1'b0}}, 1'b1} << c;
  assign m_cm1 = {{(MAX_COLS-1){1'b0}}, 1'b1} << cm1;
  assign m_cm2 = {{(MAX_COLS-1){1'b0}}, 1'b1} << cm2;
  assign m_cp1 = {{(MAX_COLS-1){1'b0}}, 1'b1} << cp1;
  assign m_cp2 = {{(MAX_COLS-1){1'b0}}, 1'b1} << cp2;

  always_comb begin
    case (dir)
      mcd_pkg::DIR_UP: begin
        e_wr = r - RW'(1);
        e_nr = r - RW'(2);
        e_wc = c;
        e_nc = c;
        e_w1 = e_wr;
        e_w2 = e_nr;
        e_d1 = rows[1] & ~m_c;
        e_d2 = rows[0] & ~m_c;
      end
      mcd_pkg::DIR_DN: begin
        e_wr = r + RW'(1);
        e_nr = r + RW'(2);
        e_wc = c;
        e_nc = c;
        e_w1 = e_wr;
        e_w2 = e_nr;
        e_d1 = rows[3] & ~m_c;
        e_d2 = rows[4] & ~m_c;
      end
      mcd_pkg::DIR_LF: begin
        e_wr = r;
        e_nr = r;
        e_wc = cm1;
        e_nc = cm2;
        e_w1 = r;
        e_w2 = r;
        e_d1 = rows[2] & ~m_cm1;
        e_d2 = rows[2] & ~m_cm1 & ~m_cm2;
      end
      default: begin
        e_wr = r;
        e_nr = r;
        e_wc = cp1;
        e_nc = cp2;
        e_w1 = r;
        e_w2 = r;
        e_d1 = rows[2] & ~m_cp1;
        e_d2 = rows[2] & ~m_cp1 & ~m_cp2;
      end
    endcase
  end

  // sequencer
  logic          accept;
  logic          emit, emit_moved, emit_done;
  logic [LW-1:0] level_m1;
  logic          can_push;

  assign accept   = start & (state == mcd_pkg::ST_IDLE);
  assign level_m1 = level - LW'(1);
  assign can_push = level < LW'(STACK_DEPTH);
  assign busy     = (state != mcd_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    g_clr      = 1'b0;
    g_we       = 1'b0;
    g_waddr    = r;
    g_wdata    = w1_data;
    g_raddr    = row_addr;
    s_we       = 1'b0;
    s_waddr    = level[AW-1:0];
    s_wdata    = {nr_q, nc_q};
    s_raddr    = level_m1[AW-1:0];
    emit       = 1'b0;
    emit_moved = 1'b0;
    emit_done  = 1'b0;
    case (state)
      mcd_pkg::ST_IDLE: begin
        if (accept) begin
          if (!cmd) begin
            g_clr      = 1'b1;
            s_we       = 1'b1;
            s_waddr    = '0;
            s_wdata    = {RW'(1), CW'(1)};
            state_next = mcd_pkg::ST_INIT0;
          end else if (finished || (level == '0)) begin
            emit      = 1'b1;
            emit_done = 1'b1;
          end else begin
            state_next = mcd_pkg::ST_POS;
          end
        end
      end
      mcd_pkg::ST_INIT0: begin
        g_we       = 1'b1;
        g_waddr    = RW'(0);
        g_wdata    = ~({{(MAX_COLS-1){1'b0}}, 1'b1} << 1);
        state_next = mcd_pkg::ST_INIT1;
      end
      mcd_pkg::ST_INIT1: begin
        g_we       = 1'b1;
        g_waddr    = RW'(1);
        g_wdata    = ~({{(MAX_COLS-1){1'b0}}, 1'b1} << 1);
        emit       = 1'b1;
        state_next = mcd_pkg::ST_IDLE;
      end
      mcd_pkg::ST_POS: begin
        state_next = mcd_pkg::ST_ROW;
      end
      mcd_pkg::ST_ROW: begin
        if (idx == 3'd4) begin
          state_next = mcd_pkg::ST_WAIT;
        end
      end
      mcd_pkg::ST_WAIT: begin
        state_next = mcd_pkg::ST_EVAL;
      end
      mcd_pkg::ST_EVAL: begin
        if (n_open != 3'd0) begin
          state_next = mcd_pkg::ST_WR1;
        end else begin
          emit       = 1'b1;
          emit_done  = (level == LW'(1));
          state_next = mcd_pkg::ST_IDLE;
        end
      end
      mcd_pkg::ST_WR1: begin
        g_we       = 1'b1;
        g_waddr    = w1_row;
        g_wdata    = w1_data;
        state_next = mcd_pkg::ST_WR2;
      end
      mcd_pkg::ST_WR2: begin
        g_we       = 1'b1;
        g_waddr    = w2_row;
        g_wdata    = w2_data;
        s_we       = can_push;
        emit       = 1'b1;
        emit_moved = 1'b1;
        state_next = mcd_pkg::ST_IDLE;
      end
      default: begin
        state_next = mcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      finished <= 1'b1;
      idx      <= '0;
      rd_pend  <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe  <= emit;
      rd_pend <= (state == mcd_pkg::ST_ROW);
      if (state == mcd_pkg::ST_ROW) begin
        idx <= idx + 3'd1;
      end else begin
        idx <= '0;
      end
      if (accept && !cmd) begin
        level    <= LW'(1);
        finished <= 1'b0;
      end else if (accept && emit_done) begin
        finished <= 1'b1;
      end else if (state == mcd_pkg::ST_EVAL && n_open == 3'd0) begin
        level <= level_m1;
        if (level == LW'(1)) begin
          finished <= 1'b1;
        end
      end else if (state == mcd_pkg::ST_WR2 && can_push) begin
        level <= level + LW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_slot <= idx;
    if (accept) begin
      rnd_q <= rnd;
    end
    if (state == mcd_pkg::ST_POS) begin
      r <= s_rdata[EW-1:CW];
      c <= s_rdata[CW-1:0];
    end
    if (rd_pend) begin
      rows[rd_slot] <= g_rdata;
    end
    if (state == mcd_pkg::ST_EVAL) begin
      w1_row  <= e_w1;
      w2_row  <= e_w2;
      w1_data <= e_d1;
      w2_data <= e_d2;
      wr_q    <= e_wr;
      wc_q    <= e_wc;
      nr_q    <= e_nr;
      nc_q    <= e_nc;
    end
    if (emit) begin
      moved    <= emit_moved;
      done_res <= emit_done;
      wall_row <= emit_moved ? 6'(wr_q) : 6'd0;
      wall_col <= emit_moved ? 6'(wc_q) : 6'd0;
      cell_row <= emit_moved ? 6'(nr_q) : 6'd0;
      cell_col <= emit_moved ? 6'(nc_q) : 6'd0;
    end
  end

endmodule
